/* hdl/slist_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slist_pkg
// Shared types and constants for the sorted list block: operation and status
// codes, field widths and the controller state type.
// ----------------------------------------------------------------------------
package slist_pkg;

  // Default number of table entries.
  localparam int DEPTH_DEFAULT = 16;

  // Field widths of the transactions.
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Packed bus widths (tdata padded to whole bytes).
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 8;

  // Operation codes carried on the input tuser.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // Status codes carried on the output tuser.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_PUT,
    S_DONE
  } state_t;

endpackage

/* hdl/sorted_list_insert_search_delete_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_search_delete_top
// Ascending table of signed 32-bit keys in one synchronous memory, with
// insert, search and delete operations walked entry by entry.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream (s_*) carries one operation per transaction: the
//   operation code on s_tuser and the signed key on s_tdata. The output stream
//   (m_*) returns exactly one result per operation: the status on m_tuser and
//   the entry count after the operation on m_tdata.
// Walk and flow:
//   The table is walked through a single memory port, one entry at a time
//   (address, then compare and write back). An insert walks the entries
//   above the insertion point, plus the smaller entry that ends the walk if
//   there is one; a search or delete walks up to count entries; a rejected
//   insert, an unused code, or a search or delete on an empty table skips
//   the walk. One operation is in flight at a time, and s_tready is high
//   only while the controller is idle.
// Reset:
//   rst clears the entry count and the control state; the memory contents
//   are left as they are, since only the first count entries are ever read.
// Stalls:
//   A finished result sits in the output register; the next operation is
//   accepted and processed meanwhile, and only the loading of its result
//   waits until the receiver takes the previous one.
// ----------------------------------------------------------------------------
module sorted_list_insert_search_delete_top
  import slist_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
  input  logic [OP_W-1:0]      s_tuser,   // [1:0] operation
  // Output stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [4:0] entry_count, [7:5] zero
  output logic [STATUS_W-1:0]  m_tuser    // [1:0] status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // Table memory.
  logic signed [VALUE_W-1:0] mem [0:DEPTH-1];
  logic signed [VALUE_W-1:0] rd_data;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;

  // Controller registers.
  state_t                    state, state_next;
  logic [CW-1:0]             count, count_next;
  logic [CW-1:0]             idx, idx_next;
  logic [OP_W-1:0]           op_q, op_next;
  logic signed [VALUE_W-1:0] key_q, key_next;
  logic                      found, found_next;
  logic [STATUS_W-1:0]       res_status, res_status_next;
  logic                      m_tvalid_next;
  logic [M_TDATA_W-1:0]      m_tdata_next;
  logic [STATUS_W-1:0]       m_tuser_next;

  // Decisions on the entry just read.
  logic          key_lt;
  logic          key_eq;
  logic          at_last;
  logic          at_zero;
  logic          hit;
  logic          out_free;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;

  assign key_lt   = rd_data < key_q;
  assign key_eq   = rd_data == key_q;
  assign at_last  = idx == (count - ONE_C);
  assign at_zero  = idx == '0;
  assign hit      = found || key_eq;
  assign out_free = !m_tvalid || m_tready;
  assign idx_inc  = idx + ONE_C;
  assign idx_dec  = idx - ONE_C;

  assign s_tready = (state == S_IDLE);

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            OP_INSERT: begin
              if (count == DEPTH_C) begin
                state_next = S_DONE;
              end else if (count == '0) begin
                state_next = S_PUT;
              end else begin
                state_next = S_RD;
              end
            end
            OP_SEARCH, OP_DELETE: begin
              state_next = (count == '0) ? S_DONE : S_RD;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_RD: state_next = S_CHK;
      S_CHK: begin
        if (op_q == OP_INSERT) begin
          state_next = (key_lt || at_zero) ? S_PUT : S_RD;
        end else if ((op_q == OP_SEARCH && key_eq) || at_last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RD;
        end
      end
      S_PUT: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath, memory writes and result loading.
  always_comb begin
    count_next      = count;
    idx_next        = idx;
    op_next         = op_q;
    key_next        = key_q;
    found_next      = found;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = idx[AW-1:0];
    mem_wdata       = key_q;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op_next         = s_tuser;
          key_next        = s_tdata;
          found_next      = 1'b0;
          res_status_next = ST_NOT_FOUND;
          idx_next        = '0;
          if (s_tuser == OP_INSERT) begin
            if (count == DEPTH_C) begin
              res_status_next = ST_FULL;
            end else if (count != '0) begin
              // Walk down from the top entry, shifting larger ones up.
              idx_next = count - ONE_C;
            end
          end
        end
      end
      S_RD: begin
        // Read address is idx; data arrives next cycle.
      end
      S_CHK: begin
        if (op_q == OP_INSERT) begin
          if (key_lt) begin
            idx_next = idx_inc;
          end else begin
            // Entry is not smaller: move it up one slot.
            mem_we    = 1'b1;
            mem_waddr = idx_inc[AW-1:0];
            mem_wdata = rd_data;
            if (!at_zero) begin
              idx_next = idx_dec;
            end
          end
        end else begin
          // Delete closes the gap behind the first match.
          if (found) begin
            mem_we    = 1'b1;
            mem_waddr = idx_dec[AW-1:0];
            mem_wdata = rd_data;
          end else if (key_eq) begin
            found_next = 1'b1;
          end
          if (op_q == OP_SEARCH && key_eq) begin
            res_status_next = ST_DONE;
          end else if (at_last) begin
            if (hit) begin
              res_status_next = ST_DONE;
              if (op_q == OP_DELETE) begin
                count_next = count - ONE_C;
              end
            end else begin
              res_status_next = ST_NOT_FOUND;
            end
          end else begin
            idx_next = idx_inc;
          end
        end
      end
      S_PUT: begin
        mem_we          = 1'b1;
        mem_waddr       = idx[AW-1:0];
        mem_wdata       = key_q;
        count_next      = count + ONE_C;
        res_status_next = ST_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = M_TDATA_W'(COUNT_W'(count));
          m_tuser_next  = res_status;
        end
      end
      default: begin
      end
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      m_tvalid <= m_tvalid_next;
    end
    idx        <= idx_next;
    op_q       <= op_next;
    key_q      <= key_next;
    found      <= found_next;
    res_status <= res_status_next;
    m_tdata    <= m_tdata_next;
    m_tuser    <= m_tuser_next;
  end

  // The entry count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above table size");

  // A full status is only reported when the table really is full.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status == ST_FULL) |-> count == DEPTH_C)
    else $error("full status with free entries");

  // The walk only reads entries that hold data.
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> idx < count)
    else $error("read beyond the held entries");

  // Writes never land outside the memory.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> CW'(mem_waddr) < DEPTH_C)
    else $error("write beyond the table");

endmodule
